FILE: rtl/qflt_pkg.sv
// Shared types, constants and character classes for the quoted field line tokenizer.
package qflt_pkg;

   localparam int LINE_COUNT_BITS_DEFAULT = 16;
   localparam int LINE_NUMBER_BITS        = 16;
   localparam int BYTE_BITS               = 8;

   localparam logic [BYTE_BITS-1:0] CH_QUOTE   = 8'h22;
   localparam logic [BYTE_BITS-1:0] CH_NEWLINE = 8'h0A;
   localparam logic [BYTE_BITS-1:0] CH_SPACE   = 8'h20;
   localparam logic [BYTE_BITS-1:0] CH_TAB     = 8'h09;
   localparam logic [BYTE_BITS-1:0] CH_CR      = 8'h0D;
   localparam logic [BYTE_BITS-1:0] CH_VT      = 8'h0B;
   localparam logic [BYTE_BITS-1:0] CH_FF      = 8'h0C;

   typedef enum logic [1:0] {
      MODE_NORMAL     = 2'd0,
      MODE_QUOTED     = 2'd1,
      MODE_QUOTE_SEEN = 2'd2
   } mode_type;

   typedef enum logic [1:0] {
      KIND_DATA  = 2'd0,
      KIND_EOL   = 2'd1,
      KIND_ERROR = 2'd2
   } kind_type;

   typedef struct packed {
      mode_type mode;
      logic     field_open;
      logic     line_has_fields;
      logic     error_stuck;
   } scan_state_type;

   typedef struct packed {
      kind_type                    result_kind;
      logic [BYTE_BITS-1:0]        field_byte;
      logic                        first_of_field;
      logic [LINE_NUMBER_BITS-1:0] line_number;
   } result_type;

   function automatic logic is_space(input logic [BYTE_BITS-1:0] c);
      return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_CR) ||
             (c == CH_VT) || (c == CH_FF);
   endfunction

endpackage

FILE: rtl/qflt_if.sv
// Request and response channel interfaces of the tokenizer.
interface qflt_req_if;
   import qflt_pkg::*;
   logic                 valid;
   logic                 ready;
   logic [BYTE_BITS-1:0] text_byte;
   logic                 end_of_input;

   modport source (output valid, output text_byte, output end_of_input, input ready);
   modport sink (input valid, input text_byte, input end_of_input, output ready);
endinterface

interface qflt_rsp_if;
   import qflt_pkg::*;
   logic                        valid;
   logic                        ready;
   kind_type                    result_kind;
   logic [BYTE_BITS-1:0]        field_byte;
   logic                        first_of_field;
   logic [LINE_NUMBER_BITS-1:0] line_number;

   modport source (output valid, output result_kind, output field_byte,
                   output first_of_field, output line_number, input ready);
   modport sink (input valid, input result_kind, input field_byte,
                 input first_of_field, input line_number, output ready);
endinterface

FILE: rtl/qflt_step.sv
// Combinational tokenizer step: next scan state and the result of one character.
module qflt_step #(
   parameter int LINE_COUNT_BITS = qflt_pkg::LINE_COUNT_BITS_DEFAULT
) (
   input  qflt_pkg::scan_state_type         state,
   input  logic [LINE_COUNT_BITS-1:0]       line_count,
   input  logic [qflt_pkg::BYTE_BITS-1:0]   text_byte,
   input  logic                             end_of_input,
   output qflt_pkg::scan_state_type         state_next,
   output logic [LINE_COUNT_BITS-1:0]       line_count_next,
   output logic                             emit,
   output qflt_pkg::result_type             result
);
   import qflt_pkg::*;

   logic        is_quote;
   logic        is_newline;
   logic        plain;
   logic [32:0] line_plus_one;

   assign is_quote   = (text_byte == CH_QUOTE);
   assign is_newline = (text_byte == CH_NEWLINE);
   // After a quote inside a span, anything but a second quote closes the span.
   assign plain = (state.mode == MODE_NORMAL) ||
                  ((state.mode == MODE_QUOTE_SEEN) && !is_quote);
   assign line_plus_one = 33'(line_count) + 33'd1;

   always_comb begin
      state_next      = state;
      line_count_next = line_count;
      if (!state.error_stuck) begin
         if (end_of_input) begin
            state_next.mode            = MODE_NORMAL;
            state_next.field_open      = 1'b0;
            state_next.line_has_fields = 1'b0;
         end else if (plain) begin
            state_next.mode = MODE_NORMAL;
            if (is_quote) begin
               state_next.mode = MODE_QUOTED;
            end else if (is_newline) begin
               if (line_count != {LINE_COUNT_BITS{1'b1}}) begin
                  line_count_next = line_count + LINE_COUNT_BITS'(1);
               end
               state_next.field_open      = 1'b0;
               state_next.line_has_fields = 1'b0;
            end else if (is_space(text_byte)) begin
               state_next.field_open = 1'b0;
            end else begin
               state_next.field_open      = 1'b1;
               state_next.line_has_fields = 1'b1;
            end
         end else if (state.mode == MODE_QUOTE_SEEN) begin
            state_next.mode            = MODE_QUOTED;
            state_next.field_open      = 1'b1;
            state_next.line_has_fields = 1'b1;
         end else begin
            if (is_newline) begin
               state_next.error_stuck = 1'b1;
            end else if (is_quote) begin
               state_next.mode = MODE_QUOTE_SEEN;
            end else begin
               state_next.field_open      = 1'b1;
               state_next.line_has_fields = 1'b1;
            end
         end
      end
   end

   always_comb begin
      emit                  = 1'b0;
      result.result_kind    = KIND_DATA;
      result.field_byte     = text_byte;
      result.first_of_field = !state.field_open;
      result.line_number    = (line_plus_one > 33'd65535) ? {LINE_NUMBER_BITS{1'b1}}
                                                         : line_plus_one[LINE_NUMBER_BITS-1:0];
      if (!state.error_stuck) begin
         if (end_of_input) begin
            emit               = state.line_has_fields;
            result.result_kind = KIND_EOL;
         end else if (plain) begin
            if (is_newline) begin
               emit               = 1'b1;
               result.result_kind = KIND_EOL;
            end else begin
               emit = !is_quote && !is_space(text_byte);
            end
         end else if (state.mode == MODE_QUOTE_SEEN) begin
            emit = 1'b1;
         end else begin
            if (is_newline) begin
               emit               = 1'b1;
               result.result_kind = KIND_ERROR;
            end else begin
               emit = !is_quote;
            end
         end
      end
      if (result.result_kind != KIND_DATA) begin
         result.field_byte     = '0;
         result.first_of_field = 1'b0;
      end
   end

endmodule

FILE: rtl/quoted_field_line_tokenizer.sv
// Top level of the quoted field line tokenizer: input register, scan state, result register.
// Order: a request is registered in the input register at acceptance, and its result, if any,
// is loaded into the result register when the scan step consumes that request.
// Throughput: one request per cycle while the result register is not stalled.
// Reset: synchronous, active high; empties both registers and returns to normal mode,
// no open field, line count zero and no error.
module quoted_field_line_tokenizer #(
   parameter int LINE_COUNT_BITS = qflt_pkg::LINE_COUNT_BITS_DEFAULT
) (
   input logic       clock,
   input logic       reset,
   qflt_req_if.sink  req_chan,
   qflt_rsp_if.source rsp_chan
);
   import qflt_pkg::*;

   // Input register: holds one accepted request until the scan step consumes it.
   logic                 in_valid_ff, in_valid_in;
   logic [BYTE_BITS-1:0] in_byte_ff;
   logic                 in_end_ff;

   // Scan state, advanced once per consumed request.
   scan_state_type             state_ff, state_in;
   logic [LINE_COUNT_BITS-1:0] line_count_ff, line_count_in;

   // Result register: the output side stalls here and holds back the scan step only
   // while the register is full and not taken.
   logic       out_valid_ff, out_valid_in;
   result_type out_ff;

   logic       step_fire;
   logic       step_emit;
   result_type step_result;

   // The step consumes the held request whenever the result register can take
   // whatever it produces: it is empty or is being emptied this cycle.
   assign step_fire      = in_valid_ff && (!out_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !in_valid_ff || step_fire;

   qflt_step #(
      .LINE_COUNT_BITS (LINE_COUNT_BITS)
   ) u_step (
      .state           (state_ff),
      .line_count      (line_count_ff),
      .text_byte       (in_byte_ff),
      .end_of_input    (in_end_ff),
      .state_next      (state_in),
      .line_count_next (line_count_in),
      .emit            (step_emit),
      .result          (step_result)
   );

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_chan.valid && req_chan.ready) begin
         in_valid_in = 1'b1;
      end else if (step_fire) begin
         in_valid_in = 1'b0;
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      if (step_fire) begin
         out_valid_in = step_emit;
      end else if (rsp_chan.ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff   <= 1'b0;
         out_valid_ff  <= 1'b0;
         state_ff      <= '{mode: MODE_NORMAL, field_open: 1'b0,
                            line_has_fields: 1'b0, error_stuck: 1'b0};
         line_count_ff <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (step_fire) begin
            state_ff      <= state_in;
            line_count_ff <= line_count_in;
         end
      end
   end

   // Payload registers carry no reset; their valid bits qualify them.
   always_ff @(posedge clock) begin
      if (req_chan.valid && req_chan.ready) begin
         in_byte_ff <= req_chan.text_byte;
         in_end_ff  <= req_chan.end_of_input;
      end
      if (step_fire && step_emit) begin
         out_ff <= step_result;
      end
   end

   assign rsp_chan.valid          = out_valid_ff;
   assign rsp_chan.result_kind    = out_ff.result_kind;
   assign rsp_chan.field_byte     = out_ff.field_byte;
   assign rsp_chan.first_of_field = out_ff.first_of_field;
   assign rsp_chan.line_number    = out_ff.line_number;

endmodule

FILE: rtl/qflt_checker.sv
// Port-level assertions for the tokenizer and the bind that attaches them.
module qflt_checker (
   input logic                                  clock,
   input logic                                  reset,
   input logic                                  rsp_valid,
   input logic                                  rsp_ready,
   input qflt_pkg::kind_type                    rsp_result_kind,
   input logic [qflt_pkg::BYTE_BITS-1:0]        rsp_field_byte,
   input logic                                  rsp_first_of_field,
   input logic [qflt_pkg::LINE_NUMBER_BITS-1:0] rsp_line_number
);
   import qflt_pkg::*;

   a_reset_empties: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid &&
         $stable(rsp_result_kind) && $stable(rsp_field_byte) &&
         $stable(rsp_first_of_field) && $stable(rsp_line_number))
      else $error("stalled response changed");

   a_silent_after_error: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && (rsp_result_kind == KIND_ERROR)
         |=> !rsp_valid)
      else $error("response after runaway quote error");

   a_control_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_result_kind != KIND_DATA) |->
         (rsp_field_byte == '0) && !rsp_first_of_field &&
         (rsp_result_kind == KIND_EOL || rsp_result_kind == KIND_ERROR))
      else $error("malformed line end or error response");

   a_line_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_line_number != '0))
      else $error("line number zero");

endmodule

bind quoted_field_line_tokenizer qflt_checker u_qflt_checker (
   .clock              (clock),
   .reset              (reset),
   .rsp_valid          (rsp_chan.valid),
   .rsp_ready          (rsp_chan.ready),
   .rsp_result_kind    (rsp_chan.result_kind),
   .rsp_field_byte     (rsp_chan.field_byte),
   .rsp_first_of_field (rsp_chan.first_of_field),
   .rsp_line_number    (rsp_chan.line_number)
);
